### sv/ubds_pkg.sv
// ubds_pkg: shared types and constants for the baud divisor search block
// no dependencies; used by uart_baud_divisor_search and ubds_cell
package ubds_pkg;

    localparam int CLK_BITS        = 32;
    localparam int BAUD_BITS       = 24;
    localparam int RATIO_BITS      = 7;
    localparam int DIV_BITS        = 16;
    localparam int BOTH_EDGE_LIMIT = 8;
    localparam int UNSUP_PCT       = 3;
    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for any 24-bit x
    localparam int DIV100_MUL      = 21474837;
    localparam int DIV100_SHIFT    = 31;
    localparam int PCT_BITS        = 18;

    typedef struct packed {
        logic                 valid;
        logic [CLK_BITS-1:0]  clock_hz;
        logic [BAUD_BITS-1:0] target_baud;
    } ubds_req_t;

    typedef struct packed {
        logic                  valid;
        logic [BAUD_BITS-1:0]  target;
        logic [BAUD_BITS-1:0]  err;
        logic [RATIO_BITS-1:0] ratio;
        logic [DIV_BITS-1:0]   div;
    } ubds_best_t;

endpackage

### sv/ubds_if.sv
// ubds_req_if / ubds_rsp_if: valid/ready channels of the baud divisor search
// no dependencies
interface ubds_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_hz;
    logic [23:0] target_baud;
    modport source (output valid, clock_hz, target_baud, input ready);
    modport sink (input valid, clock_hz, target_baud, output ready);
endinterface

interface ubds_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  oversample_ratio;
    logic [12:0] divisor;
    logic        both_edge;
    logic [23:0] rate_error;
    logic        unsupported;
    modport source (output valid, oversample_ratio, divisor, both_edge, rate_error,
                    unsupported, input ready);
    modport sink (input valid, oversample_ratio, divisor, both_edge, rate_error,
                  unsupported, output ready);
endinterface

### sv/uart_baud_divisor_search.sv
// uart_baud_divisor_search: picks oversampling ratio and baud divisor for a uart
// throughput: one request beat per cycle, set by the fully pipelined dividers,
// while the result beat is not stalled
// reset: asynchronous active-low rst_n clears all valid and control state
// depends on ubds_pkg, ubds_if, ubds_div, ubds_cell
module uart_baud_divisor_search #(
    parameter int DIVISOR_MAX = 8191,
    parameter int RATIO_MIN   = 4,
    parameter int RATIO_MAX   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    ubds_req_if.sink          req,
    ubds_rsp_if.source        rsp
);

    // one cell per ratio; an empty range keeps a single cell that never takes
    localparam bit ACTIVE = (RATIO_MIN <= RATIO_MAX);
    localparam int NCELL  = ACTIVE ? (RATIO_MAX - RATIO_MIN + 1) : 1;
    localparam int BW     = ubds_pkg::BAUD_BITS;
    localparam int RW     = ubds_pkg::RATIO_BITS;
    localparam int PCW    = ubds_pkg::PCT_BITS;
    localparam int PRW    = BW + 25;
    localparam int LMW    = PCW + 2;

    // whole pipeline moves together; it stalls only when the output beat waits
    logic en;

    ubds_pkg::ubds_req_t  req_chain  [NCELL+1];
    ubds_pkg::ubds_best_t best_chain [NCELL+1];

    // percent stage
    ubds_pkg::ubds_best_t a_best_reg;
    logic [PCW-1:0]       a_pct_reg;
    logic [PRW-1:0]       pct_prod;

    // output register
    logic                 out_valid_reg;
    logic [RW-1:0]        out_ratio_reg;
    logic [ubds_pkg::DIV_BITS-1:0] out_div_reg;
    logic [BW-1:0]        out_err_reg;
    logic                 out_both_reg;
    logic                 out_unsup_reg;
    logic [LMW-1:0]       limit;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    assign req_chain[0].valid       = req.valid;
    assign req_chain[0].clock_hz    = req.clock_hz;
    assign req_chain[0].target_baud = req.target_baud;
    // first cell seeds the best with its own target
    assign best_chain[0]            = '0;

    // each cell takes the request through its left neighbor's request register, so its
    // candidate lines up with the neighbor's registered best
    genvar k;
    for (k = 0; k < NCELL; k++)
    begin : g_cell
        ubds_cell #(
            .RATIO      (ACTIVE ? (RATIO_MIN + k) : 1),
            .DIVISOR_MAX(DIVISOR_MAX),
            .ACTIVE     (ACTIVE),
            .FIRST      (k == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .req_in  (req_chain[k]),
            .best_in (best_chain[k]),
            .req_out (req_chain[k+1]),
            .best_out(best_chain[k+1])
        );
    end

    // floor(target / 100) by reciprocal multiply
    assign pct_prod = PRW'(best_chain[NCELL].target) * PRW'(ubds_pkg::DIV100_MUL);
    assign limit    = LMW'(a_pct_reg) * LMW'(ubds_pkg::UNSUP_PCT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_best_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_best_reg    <= best_chain[NCELL];
            out_valid_reg <= a_best_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pct_reg     <= pct_prod[ubds_pkg::DIV100_SHIFT +: PCW];
            out_ratio_reg <= a_best_reg.ratio;
            out_div_reg   <= a_best_reg.div;
            out_err_reg   <= a_best_reg.err;
            out_both_reg  <= (a_best_reg.ratio != '0) &&
                             (a_best_reg.ratio < RW'(ubds_pkg::BOTH_EDGE_LIMIT));
            out_unsup_reg <= (a_best_reg.err >= BW'(limit));
        end
    end

    // ratio is reported masked to the 6-bit field
    assign rsp.valid            = out_valid_reg;
    assign rsp.oversample_ratio = out_ratio_reg[5:0];
    assign rsp.divisor          = out_div_reg[12:0];
    assign rsp.both_edge        = out_both_reg;
    assign rsp.rate_error       = out_err_reg;
    assign rsp.unsupported      = out_unsup_reg;

    // a kept candidate always has both a ratio and a divisor
    a_found_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_ratio_reg == '0) == (out_div_reg == '0)))
        else $error("ratio and divisor disagree on whether a candidate was kept");

    // no candidate means the error is the whole target, always unsupported
    a_none_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ratio_reg == '0) |-> out_unsup_reg)
        else $error("no candidate but not flagged unsupported");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(out_div_reg) <= 32'(DIVISOR_MAX)))
        else $error("divisor above maximum");

    // a stalled result beat holds and the pipeline behind it is frozen
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(out_err_reg) && $stable(a_best_reg)))
        else $error("pipeline moved during stall");

endmodule

### sv/ubds_div.sv
// ubds_div: pipelined restoring divider, one quotient bit per stage
// carries a side payload alongside; no package dependency
module ubds_div #(
    parameter int NW = 33,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [NW];
    logic [NW-1:0] num_reg   [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    genvar i;
    for (i = 0; i < NW; i++)
    begin : g_stage
        logic          v_in;
        logic [NW-1:0] n_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   shifted;
        logic [DW+1:0] diff;
        logic          ok;

        if (i == 0)
        begin : g_head
            assign v_in = in_valid;
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign s_in = side;
        end
        else
        begin : g_body
            assign v_in = valid_reg[i-1];
            assign n_in = num_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign d_in = den_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign shifted = {r_in, n_in[NW-1]};
        assign diff    = {1'b0, shifted} - {2'b00, d_in};
        assign ok      = !diff[DW+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i]  <= {n_in[NW-2:0], ok};
                rem_reg[i]  <= ok ? diff[DW-1:0] : shifted[DW-1:0];
                den_reg[i]  <= d_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo       = num_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

### sv/ubds_cell.sv
// ubds_cell: one oversampling ratio of the search chain
// depends on ubds_pkg and ubds_div
module ubds_cell #(
    parameter int RATIO       = 4,
    parameter int DIVISOR_MAX = 8191,
    parameter bit ACTIVE      = 1'b1,
    parameter bit FIRST       = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ubds_pkg::ubds_req_t  req_in,
    input  ubds_pkg::ubds_best_t best_in,
    output ubds_pkg::ubds_req_t  req_out,
    output ubds_pkg::ubds_best_t best_out
);

    localparam int RW  = ubds_pkg::RATIO_BITS;
    localparam int BW  = ubds_pkg::BAUD_BITS;
    localparam int CW  = ubds_pkg::CLK_BITS;
    localparam int DVW = $clog2(DIVISOR_MAX + 1);
    localparam int D1W = BW + RW;
    localparam int PW  = RW + DVW;
    localparam int SW1 = CW + BW;
    localparam int SW2 = DVW + BW;

    ubds_pkg::ubds_req_t  req_reg;
    ubds_pkg::ubds_best_t best_reg;
    ubds_pkg::ubds_best_t best_next;

    // target * ratio
    logic           m_valid_reg;
    logic [D1W-1:0] m_den_reg;
    logic [CW-1:0]  m_clk_reg;
    logic [BW-1:0]  m_tgt_reg;

    logic           q1_valid;
    logic [CW:0]    q1;
    logic [SW1-1:0] q1_side;
    logic [CW+1:0]  rnd;
    logic [CW:0]    q_rnd;
    logic [DVW-1:0] div_next;

    logic           r_valid_reg;
    logic [DVW-1:0] r_div_reg;
    logic [SW1-1:0] r_side_reg;

    logic           p_valid_reg;
    logic [PW-1:0]  p_prod_reg;
    logic [DVW-1:0] p_div_reg;
    logic [SW1-1:0] p_side_reg;

    logic           q2_valid;
    logic [CW-1:0]  actual;
    logic [SW2-1:0] q2_side;
    logic [BW-1:0]  tgt;
    logic [DVW-1:0] div_fin;
    logic [CW-1:0]  tgt_ext;
    logic [CW-1:0]  err;
    ubds_pkg::ubds_best_t base;
    logic           take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg     <= '0;
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            best_reg    <= '0;
        end
        else if (en)
        begin
            req_reg     <= req_in;
            m_valid_reg <= req_in.valid;
            r_valid_reg <= q1_valid;
            p_valid_reg <= r_valid_reg;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_den_reg  <= D1W'(req_in.target_baud) * D1W'(RATIO);
            m_clk_reg  <= req_in.clock_hz;
            m_tgt_reg  <= req_in.target_baud;
            r_div_reg  <= div_next;
            r_side_reg <= q1_side;
            p_prod_reg <= PW'(RATIO) * PW'(r_div_reg);
            p_div_reg  <= r_div_reg;
            p_side_reg <= r_side_reg;
        end
    end

    // floor 2*clk/(target*ratio) for rounding; a zero denominator gives all ones
    ubds_div #(.NW(CW + 1), .DW(D1W), .SW(SW1)) u_div_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (m_valid_reg),
        .num      ({m_clk_reg, 1'b0}),
        .den      (m_den_reg),
        .side     ({m_clk_reg, m_tgt_reg}),
        .out_valid(q1_valid),
        .quo      (q1),
        .side_out (q1_side)
    );

    assign rnd   = {1'b0, q1} + (CW + 2)'(1);
    assign q_rnd = rnd[CW+1:1];

    always_comb
    begin
        if (q_rnd == '0)
        begin
            div_next = DVW'(1);
        end
        else if (q_rnd > (CW + 1)'(DIVISOR_MAX))
        begin
            div_next = DVW'(DIVISOR_MAX);
        end
        else
        begin
            div_next = q_rnd[DVW-1:0];
        end
    end

    // achieved rate clk / (ratio * divisor)
    ubds_div #(.NW(CW), .DW(PW), .SW(SW2)) u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (p_valid_reg),
        .num      (p_side_reg[SW1-1:BW]),
        .den      (p_prod_reg),
        .side     ({p_div_reg, p_side_reg[BW-1:0]}),
        .out_valid(q2_valid),
        .quo      (actual),
        .side_out (q2_side)
    );

    assign tgt     = q2_side[BW-1:0];
    assign div_fin = q2_side[SW2-1:BW];
    assign tgt_ext = CW'(tgt);
    assign err     = (actual > tgt_ext) ? (actual - tgt_ext) : (tgt_ext - actual);

    always_comb
    begin
        if (FIRST)
        begin
            base        = '0;
            base.target = tgt;
            base.err    = tgt;
        end
        else
        begin
            base = best_in;
        end
        // ties go to the later ratio
        take = ACTIVE && (err <= CW'(base.err));
        best_next        = base;
        best_next.valid  = q2_valid;
        best_next.target = tgt;
        if (take)
        begin
            best_next.err   = err[BW-1:0];
            best_next.ratio = RW'(RATIO);
            best_next.div   = ubds_pkg::DIV_BITS'(div_fin);
        end
    end

    assign req_out  = req_reg;
    assign best_out = best_reg;

endmodule
